@@ rtl/core/led_ring_progress_renderer_assert.svh @@
// Assertion macros used by the renderer RTL.
`ifndef LED_RING_PROGRESS_RENDERER_ASSERT_SVH
`define LED_RING_PROGRESS_RENDERER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define LRPR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LRPR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/lrpr_pkg.sv @@
// Types, constants and color helpers for the LED ring progress renderer.
package lrpr_pkg;

	localparam int MaxPixels = 64;
	localparam int ProgW     = 17;
	localparam int CntW      = 7;
	localparam int IdxW      = 6;
	localparam int PosW      = 23;
	localparam int ColW      = 24;
	localparam int AddrW     = 9;
	localparam int InDataW   = 24;
	localparam int OutDataW  = 40;
	localparam int DivW      = 17;
	localparam int DvsW      = 7;
	localparam int DivSteps  = 17;

	localparam logic [ProgW-1:0] PROG_FULL = 17'h10000;
	localparam logic [CntW-1:0]  CNT_MIN   = 7'd2;
	localparam logic [CntW-1:0]  CNT_MAX   = 7'(MaxPixels);

	// register indexes
	localparam logic [2:0] REG_COLOR_MODE   = 3'd0;
	localparam logic [2:0] REG_FILL_COLOR   = 3'd1;
	localparam logic [2:0] REG_FILL_END     = 3'd2;
	localparam logic [2:0] REG_EMPTY_COLOR  = 3'd3;
	localparam logic [2:0] REG_PIXEL_COUNT  = 3'd4;
	localparam logic [2:0] REG_START_OFFSET = 3'd5;

	// color modes
	localparam logic [1:0] MODE_SOLID   = 2'd0;
	localparam logic [1:0] MODE_RAINBOW = 2'd1;
	localparam logic [1:0] MODE_PROG    = 2'd2;
	localparam logic [1:0] MODE_POS     = 2'd3;

	// divider jobs run before a ring is emitted
	localparam logic [1:0] JOB_HUE   = 2'd0;
	localparam logic [1:0] JOB_RED   = 2'd1;
	localparam logic [1:0] JOB_GREEN = 2'd2;
	localparam logic [1:0] JOB_BLUE  = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PREP = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_RUN  = 4'b1000
	} seq_state_t;

	typedef struct packed {
		logic            start;
		logic [DivW-1:0] dividend;
		logic [DvsW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [DivW-1:0] quo;
		logic [DvsW-1:0] rem;
	} div_rsp_t;

	// six-sector hue ramp, k in 0..1530
	function automatic logic [ColW-1:0] hue_rgb(input logic [10:0] k);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		r = 8'd255;
		g = 8'd0;
		b = 8'd0;
		priority if (k < 11'd255) begin
			r = 8'd255; g = k[7:0]; b = 8'd0;
		end else if (k < 11'd510) begin
			r = 8'(11'd510 - k); g = 8'd255; b = 8'd0;
		end else if (k < 11'd765) begin
			r = 8'd0; g = 8'd255; b = 8'(k - 11'd510);
		end else if (k < 11'd1020) begin
			r = 8'd0; g = 8'(11'd1020 - k); b = 8'd255;
		end else if (k < 11'd1275) begin
			r = 8'(k - 11'd1020); g = 8'd0; b = 8'd255;
		end else if (k < 11'd1530) begin
			r = 8'd255; g = 8'd0; b = 8'(11'd1530 - k);
		end else begin
			r = 8'd255; g = 8'd0; b = 8'd0;
		end
		return {r, g, b};
	endfunction

	// floor(a + (b - a) * f / 65536), f in 0..65536
	function automatic logic [7:0] blend_chan(input logic [7:0] a, input logic [7:0] b,
			input logic [ProgW-1:0] f);
		logic signed [8:0]  diff;
		logic signed [17:0] fs;
		logic signed [26:0] prod;
		logic signed [10:0] sum;
		diff = $signed({1'b0, b}) - $signed({1'b0, a});
		fs   = $signed({1'b0, f});
		prod = diff * fs;
		sum  = $signed({3'b000, a}) + $signed(11'(prod >>> 16));
		return sum[7:0];
	endfunction

	function automatic logic [ColW-1:0] blend_rgb(input logic [ColW-1:0] a,
			input logic [ColW-1:0] b, input logic [ProgW-1:0] f);
		return {blend_chan(a[23:16], b[23:16], f), blend_chan(a[15:8], b[15:8], f),
			blend_chan(a[7:0], b[7:0], f)};
	endfunction

endpackage

@@ rtl/core/led_ring_progress_renderer.sv @@
// Antialiased LED ring progress renderer: top level.
// Each progress value taken on the input stream (Q1.16, 65536 = full) is turned into one
// transfer per ring pixel, pixel 0 first, with tlast on the final pixel. Pixels leave at one
// per cycle through a three-stage pipeline that stalls as a whole on output backpressure.
// A new progress value is taken once every pixel of the previous ring has been issued.
// Before a ring is emitted, rainbow mode runs one division on the shared serial divider
// to work out the per-ring hue step, and position-gradient mode runs three divisions to
// work out the per-channel gradient steps; solid and progress-gradient modes use none.
`include "led_ring_progress_renderer_assert.svh"

module led_ring_progress_renderer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [lrpr_pkg::InDataW-1:0]  s_axis_tdata,   // [16:0] progress
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [lrpr_pkg::OutDataW-1:0] m_axis_tdata,   // [8:0] pixel_address, [16:9] red,
	                                                      // [24:17] green, [32:25] blue
	output logic                          m_axis_tlast,   // last_pixel
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [lrpr_pkg::ColW-1:0]     cfg_data
);
	import lrpr_pkg::*;

	// configuration
	logic [1:0]      color_mode_q;
	logic [ColW-1:0] fill_color_q;
	logic [ColW-1:0] fill_end_q;
	logic [ColW-1:0] empty_color_q;
	logic [CntW-1:0] pixel_count_q;
	logic [7:0]      start_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q   <= MODE_SOLID;
			fill_color_q   <= 24'hFFFFFF;
			fill_end_q     <= '0;
			empty_color_q  <= '0;
			pixel_count_q  <= 7'd60;
			start_offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLOR_MODE:   color_mode_q   <= cfg_data[1:0];
				REG_FILL_COLOR:   fill_color_q   <= cfg_data;
				REG_FILL_END:     fill_end_q     <= cfg_data;
				REG_EMPTY_COLOR:  empty_color_q  <= cfg_data;
				REG_PIXEL_COUNT:  pixel_count_q  <= cfg_data[CntW-1:0];
				REG_START_OFFSET: start_offset_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer
	seq_state_t      st_q;
	logic [1:0]      job_q;
	logic            job_active_q;
	logic [ProgW-1:0] p_q;
	logic [CntW-1:0] n_q;
	logic [PosW-1:0] pos_q;
	logic [ColW-1:0] solid_q;
	logic [IdxW-1:0] i_q;
	logic [15:0]     hq_q;
	logic [IdxW-1:0] hr_q;
	logic [15:0]     hstep_q;
	logic [IdxW-1:0] hrstep_q;
	logic [7:0]      cq_q [3];
	logic [IdxW-1:0] cr_q [3];
	logic signed [9:0] cstep_q [3];
	logic [IdxW-1:0] crstep_q [3];

	logic            take;
	logic            adv;
	logic            issue;
	logic            last_c;
	logic [CntW-1:0] den;
	logic [ProgW-1:0] p_in;
	logic [CntW-1:0] n_in;
	logic [7:0]      fc_ch [3];
	logic [7:0]      fe_ch [3];
	logic [7:0]      ja;
	logic [7:0]      jb;
	logic            jneg;
	logic [7:0]      jmag;
	div_req_t        div_req;
	div_rsp_t        div_rsp;
	logic [CntW-1:0] hsum;
	logic [CntW-1:0] csum [3];

	logic            v_s1;
	logic            v_s2;
	logic            v_s3;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign take  = s_axis_tvalid && s_axis_tready;
	assign adv   = !v_s3 || m_axis_tready;
	assign issue = (st_q == ST_RUN) && adv;
	assign den   = n_q - 7'd1;
	assign last_c = ({1'b0, i_q} == den);

	assign p_in = (s_axis_tdata[ProgW-1:0] > PROG_FULL) ? PROG_FULL : s_axis_tdata[ProgW-1:0];
	always_comb begin
		n_in = pixel_count_q;
		priority if (pixel_count_q < CNT_MIN) n_in = CNT_MIN;
		else if (pixel_count_q > CNT_MAX) n_in = CNT_MAX;
		else n_in = pixel_count_q;
	end

	assign fc_ch[0] = fill_color_q[23:16];
	assign fc_ch[1] = fill_color_q[15:8];
	assign fc_ch[2] = fill_color_q[7:0];
	assign fe_ch[0] = fill_end_q[23:16];
	assign fe_ch[1] = fill_end_q[15:8];
	assign fe_ch[2] = fill_end_q[7:0];

	always_comb begin
		unique case (job_q)
			JOB_RED:   begin ja = fc_ch[0]; jb = fe_ch[0]; end
			JOB_GREEN: begin ja = fc_ch[1]; jb = fe_ch[1]; end
			JOB_BLUE:  begin ja = fc_ch[2]; jb = fe_ch[2]; end
			default:   begin ja = '0; jb = '0; end
		endcase
		jneg = jb < ja;
		jmag = jneg ? 8'(ja - jb) : 8'(jb - ja);
	end

	assign div_req = '{
		start:    (st_q == ST_DIV) && !job_active_q,
		dividend: (job_q == JOB_HUE) ? PROG_FULL : {9'd0, jmag},
		divisor:  (job_q == JOB_HUE) ? n_q : den
	};

	lrpr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign hsum = {1'b0, hr_q} + {1'b0, hrstep_q};
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			csum[c] = {1'b0, cr_q[c]} + {1'b0, crstep_q[c]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			job_q        <= JOB_HUE;
			job_active_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (take) st_q <= ST_PREP;
				ST_PREP: begin
					priority if (color_mode_q == MODE_RAINBOW) begin
						st_q  <= ST_DIV;
						job_q <= JOB_HUE;
					end else if (color_mode_q == MODE_POS) begin
						st_q  <= ST_DIV;
						job_q <= JOB_RED;
					end else begin
						st_q <= ST_RUN;
					end
				end
				ST_DIV: begin
					if (div_req.start) job_active_q <= 1'b1;
					if (div_rsp.done) begin
						job_active_q <= 1'b0;
						if (job_q == JOB_HUE || job_q == JOB_BLUE) st_q <= ST_RUN;
						else job_q <= job_q + 2'd1;
					end
				end
				ST_RUN: if (issue && last_c) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			p_q <= p_in;
			n_q <= n_in;
		end
		if (st_q == ST_PREP) begin
			pos_q   <= PosW'(p_q) * PosW'(n_q);
			solid_q <= (color_mode_q == MODE_PROG) ? blend_rgb(fill_color_q, fill_end_q, p_q)
				: fill_color_q;
			i_q  <= '0;
			hq_q <= '0;
			hr_q <= '0;
			for (int c = 0; c < 3; c++) begin
				cq_q[c] <= fc_ch[c];
				cr_q[c] <= '0;
			end
		end
		if (st_q == ST_DIV && div_rsp.done) begin
			if (job_q == JOB_HUE) begin
				hstep_q  <= div_rsp.quo[15:0];
				hrstep_q <= div_rsp.rem[IdxW-1:0];
			end
			for (int c = 0; c < 3; c++) begin
				if (job_q == 2'(c + 1)) begin
					// floor division of a signed step from a magnitude quotient
					priority if (!jneg) begin
						cstep_q[c]  <= $signed({2'b00, div_rsp.quo[7:0]});
						crstep_q[c] <= div_rsp.rem[IdxW-1:0];
					end else if (div_rsp.rem == '0) begin
						cstep_q[c]  <= -$signed({2'b00, div_rsp.quo[7:0]});
						crstep_q[c] <= '0;
					end else begin
						cstep_q[c]  <= -$signed({2'b00, div_rsp.quo[7:0]}) - 10'sd1;
						crstep_q[c] <= IdxW'(den - div_rsp.rem);
					end
				end
			end
		end
		if (issue && !last_c) begin
			i_q <= i_q + 6'd1;
			if (hsum >= n_q) begin
				hr_q <= IdxW'(hsum - n_q);
				hq_q <= hq_q + hstep_q + 16'd1;
			end else begin
				hr_q <= hsum[IdxW-1:0];
				hq_q <= hq_q + hstep_q;
			end
			for (int c = 0; c < 3; c++) begin
				if (csum[c] >= den) begin
					cr_q[c] <= IdxW'(csum[c] - den);
					cq_q[c] <= 8'($signed({2'b00, cq_q[c]}) + cstep_q[c] + 10'sd1);
				end else begin
					cr_q[c] <= csum[c][IdxW-1:0];
					cq_q[c] <= 8'($signed({2'b00, cq_q[c]}) + cstep_q[c]);
				end
			end
		end
	end

	// pixel pipeline
	logic [26:0]      kprod;
	logic [10:0]      k_s1;
	logic             full_s1, part_s1, last_s1;
	logic [15:0]      frac_s1;
	logic [ColW-1:0]  grad_s1, solid_s1;
	logic [AddrW-1:0] addr_s1;
	logic [ColW-1:0]  target_s2;
	logic             full_s2, part_s2, last_s2;
	logic [15:0]      frac_s2;
	logic [AddrW-1:0] addr_s2;
	logic [ColW-1:0]  col_s3;
	logic [AddrW-1:0] addr_s3;
	logic             last_s3;
	logic [ColW-1:0]  target_c;
	logic [ColW-1:0]  col_c;

	assign kprod = hq_q * 11'd1530 + 27'd32768;

	always_comb begin
		unique case (color_mode_q)
			MODE_RAINBOW: target_c = hue_rgb(k_s1);
			MODE_POS:     target_c = grad_s1;
			default:      target_c = solid_s1;
		endcase
	end

	always_comb begin
		priority if (full_s2) col_c = target_s2;
		else if (part_s2) col_c = blend_rgb(empty_color_q, target_s2, {1'b0, frac_s2});
		else col_c = empty_color_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1     <= kprod[26:16];
			full_s1  <= pos_q[PosW-1:16] > {1'b0, i_q};
			part_s1  <= (pos_q[PosW-1:16] == {1'b0, i_q}) && (pos_q[15:0] != '0);
			frac_s1  <= pos_q[15:0];
			grad_s1  <= {cq_q[0], cq_q[1], cq_q[2]};
			solid_s1 <= solid_q;
			addr_s1  <= {1'b0, start_offset_q} + {3'b000, i_q};
			last_s1  <= last_c;

			target_s2 <= target_c;
			full_s2   <= full_s1;
			part_s2   <= part_s1;
			frac_s2   <= frac_s1;
			addr_s2   <= addr_s1;
			last_s2   <= last_s1;

			col_s3  <= col_c;
			addr_s3 <= addr_s2;
			last_s3 <= last_s2;
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = {7'd0, col_s3[7:0], col_s3[15:8], col_s3[23:16], addr_s3};
	assign m_axis_tlast  = last_s3;

	`LRPR_ASSERT_NXT(a_last_pixel_idles, issue && last_c, st_q == ST_IDLE, "sequencer did not stop after last pixel")
	`LRPR_ASSERT_IMP(a_div_done_owned, div_rsp.done, job_active_q && st_q == ST_DIV, "divider result with no job pending")
	`LRPR_ASSERT_IMP(a_hue_rem_range, st_q == ST_RUN && color_mode_q == MODE_RAINBOW, ({1'b0, hr_q} < n_q), "hue remainder out of range")
	`LRPR_ASSERT_IMP(a_no_take_busy, st_q != ST_IDLE, !s_axis_tready, "input ready while ring in progress")

endmodule

@@ rtl/core/lrpr_div.sv @@
// Restoring divider, one quotient bit per cycle.
module lrpr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lrpr_pkg::div_req_t req,
	output lrpr_pkg::div_rsp_t rsp
);
	import lrpr_pkg::*;

	logic            busy_q;
	logic            done_q;
	logic [4:0]      cnt_q;
	logic [DvsW-1:0] rem_q;
	logic [DivW-1:0] quo_q;
	logic [DvsW-1:0] dvs_q;
	logic [DvsW:0]   shl;
	logic [DvsW:0]   diff;
	logic            ge;

	assign shl  = {rem_q, quo_q[DivW-1]};
	assign ge   = shl >= {1'b0, dvs_q};
	assign diff = shl - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(DivSteps);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= ge ? diff[DvsW-1:0] : shl[DvsW-1:0];
			quo_q <= {quo_q[DivW-2:0], ge};
		end else if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end
	end

	assign rsp = '{done: done_q, quo: quo_q, rem: rem_q};

endmodule
